/* design/hfpd_pkg.sv */
// Shared types, constants and the arctangent table for the heading block.
// No dependencies; used by the CORDIC unit and the top level.
package hfpd_pkg;

  // Field and datapath widths.
  localparam int PosW     = 32;
  localparam int DeltaW   = 33;
  localparam int YawW     = 17;
  localparam int TolW     = 16;
  localparam int SqW      = 33;
  localparam int MulW     = 17;
  localparam int PreShift = 20;
  localparam int CordW    = 56;
  localparam int AngW     = 26;
  localparam int TableLen = 24;
  localparam int StepW    = 5;

  // APB register map.
  localparam int AddrW = 3;
  localparam logic RegIdxTolerance = 1'b0;
  localparam logic [TolW-1:0] TolReset = 16'd1;

  // Angle constants: degrees in Q16 for the accumulator, Q8 for the output.
  localparam logic signed [AngW-1:0] NinetyQ16 = 26'sd5898240;
  localparam logic signed [AngW-1:0] HalfLsbQ8 = 26'sd128;
  localparam logic signed [AngW-9:0] YawLimit  = 18'sd46080;

  // Movement is only compared against the tolerance up to this magnitude.
  localparam logic signed [DeltaW-1:0] DeltaLim = 33'sd65535;

  // atan(2^-i) in degrees times 65536, rounded to nearest.
  localparam logic signed [AngW-1:0] AtanDegQ16 [TableLen] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
    26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
    26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
    26'sd917,     26'sd458,     26'sd229,    26'sd115,
    26'sd57,      26'sd29,      26'sd14,     26'sd7,
    26'sd4,       26'sd2,       26'sd1,      26'sd0
  };

  typedef logic signed [DeltaW-1:0] delta_t;
  typedef logic signed [YawW-1:0]   yaw_t;

  // Request to the CORDIC unit.
  typedef struct packed {
    logic   start;
    delta_t dx;
    delta_t dy;
  } cordic_req_t;

  // Answer from the CORDIC unit; done is a single-cycle strobe.
  typedef struct packed {
    logic done;
    yaw_t yaw;
  } cordic_rsp_t;

endpackage

/* design/hfpd_cordic.sv */
// Iterative vectoring CORDIC: one micro-rotation per cycle on a shared add/shift unit.
// Depends on hfpd_pkg for widths, the arctangent table and the request/answer structs.
module hfpd_cordic #(
  parameter int CordicSteps = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  hfpd_pkg::cordic_req_t req,
  output hfpd_pkg::cordic_rsp_t rsp
);
  import hfpd_pkg::*;

  localparam int Steps = (CordicSteps > TableLen) ? TableLen : CordicSteps;
  localparam logic [StepW-1:0] LastStep = StepW'(Steps - 1);

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_ROT  = 3'b010,
    C_FIN  = 3'b100
  } cstate_t;

  cstate_t                  state;
  logic signed [CordW-1:0]  x, y;
  logic signed [AngW-1:0]   z;
  logic [StepW-1:0]         step;
  yaw_t                     yaw;
  logic                     done;

  logic signed [CordW-1:0]  x_in, y_in, xs, ys;
  logic signed [AngW-9:0]   z_rnd;
  yaw_t                     yaw_sat;

  // Scale the deltas by 2^20 into the rotation width.
  assign x_in = {{(CordW-DeltaW-PreShift){req.dx[DeltaW-1]}}, req.dx, {PreShift{1'b0}}};
  assign y_in = {{(CordW-DeltaW-PreShift){req.dy[DeltaW-1]}}, req.dy, {PreShift{1'b0}}};

  // Shared shifters for the current step; arithmetic shifts round towards minus infinity.
  assign xs = x >>> step;
  assign ys = y >>> step;

  // Round the Q16 angle to Q8 and saturate to plus or minus 180 degrees.
  always_comb begin
    logic signed [AngW-1:0] z_sum;
    z_sum = z + HalfLsbQ8;
    z_rnd = z_sum[AngW-1:8];
    if (z_rnd > YawLimit) begin
      yaw_sat = YawW'(YawLimit);
    end else if (z_rnd < -YawLimit) begin
      yaw_sat = YawW'(-YawLimit);
    end else begin
      yaw_sat = z_rnd[YawW-1:0];
    end
  end

  // Sequencer: load with pre-rotation, rotate, then round.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
      step  <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        C_IDLE: begin
          if (req.start) begin
            step  <= '0;
            state <= C_ROT;
          end
        end
        C_ROT: begin
          if (step == LastStep) begin
            state <= C_FIN;
          end else begin
            step <= step + 1'b1;
          end
        end
        C_FIN: begin
          done  <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      C_IDLE: begin
        if (x_in < 0) begin
          if (y_in >= 0) begin
            x <= y_in;
            y <= -x_in;
            z <= NinetyQ16;
          end else begin
            x <= -y_in;
            y <= x_in;
            z <= -NinetyQ16;
          end
        end else begin
          x <= x_in;
          y <= y_in;
          z <= '0;
        end
      end
      C_ROT: begin
        if (!y[CordW-1]) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + AtanDegQ16[step];
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - AtanDegQ16[step];
        end
      end
      C_FIN: yaw <= yaw_sat;
      default: ;
    endcase
  end

  assign rsp.done = done;
  assign rsp.yaw  = yaw;

endmodule

/* design/heading_from_position_delta_top.sv */
// Heading from successive positions: an item is accepted, the movement is checked against
// the tolerance with one shared 17x17 multiplier, then a CORDIC unit finds the heading;
// a held heading keeps the last one, and an unheld zero movement gives a heading of zero.
// Ready only while idle, so one item is in work at a time; a no-fix item leaves it idle.
// Synchronous reset clears the stored pose, sets the tolerance to 1 and empties the output.
module heading_from_position_delta_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  // Input item stream.
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [95:0]                 s_axis_tdata,  // pos_x_mm, pos_y_mm, pos_z_mm
  input  logic                        s_axis_tuser,  // no_fix
  // Result item stream.
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [119:0]                m_axis_tdata,  // out_x_mm, out_y_mm, out_z_mm,
                                                     // yaw_deg_q8, zero padding
  output logic                        m_axis_tuser,  // heading_held
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hfpd_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import hfpd_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DELTA  = 8'b0000_0010,
    S_SQX    = 8'b0000_0100,
    S_SQY    = 8'b0000_1000,
    S_SQT    = 8'b0001_0000,
    S_DECIDE = 8'b0010_0000,
    S_CWAIT  = 8'b0100_0000,
    S_EMIT   = 8'b1000_0000
  } state_t;

  state_t                     state;
  logic [TolW-1:0]            tol;
  logic signed [PosW-1:0]     px, py, pz;
  logic signed [PosW-1:0]     last_x, last_y;
  yaw_t                       last_yaw;
  delta_t                     dx, dy;
  logic [SqW-1:0]             acc;
  logic [2*TolW-1:0]          tsq;
  yaw_t                       yaw;
  logic                       held;
  logic                       out_valid;
  logic signed [PosW-1:0]     out_x, out_y, out_z;
  yaw_t                       out_yaw;
  logic                       out_held;

  logic                       in_acc, emit_ok, in_range, is_zero, hold_now, cfg_wr;
  logic signed [MulW-1:0]     mul_a, mul_b;
  logic signed [2*MulW-1:0]   prod;
  cordic_req_t                creq;
  cordic_rsp_t                crsp;

  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign emit_ok       = !out_valid || m_axis_tready;

  // Configuration register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == RegIdxTolerance);

  always_comb begin
    if (paddr[2] == RegIdxTolerance) begin
      prdata = {{(32-TolW){1'b0}}, tol};
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TolReset;
    end else if (cfg_wr) begin
      tol <= pwdata[TolW-1:0];
    end
  end

  // Shared multiplier: dx squared, dy squared, then the tolerance squared.
  always_comb begin
    case (state)
      S_SQX: begin
        mul_a = dx[MulW-1:0];
        mul_b = dx[MulW-1:0];
      end
      S_SQY: begin
        mul_a = dy[MulW-1:0];
        mul_b = dy[MulW-1:0];
      end
      S_SQT: begin
        mul_a = {1'b0, tol};
        mul_b = {1'b0, tol};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Held when both deltas are small and the squared distance is below the tolerance squared.
  assign in_range = (dx >= -DeltaLim) && (dx <= DeltaLim) &&
                    (dy >= -DeltaLim) && (dy <= DeltaLim);
  assign hold_now = in_range && (acc < {1'b0, tsq});
  assign is_zero  = (dx == '0) && (dy == '0);

  assign creq.start = (state == S_DECIDE) && !hold_now && !is_zero;
  assign creq.dx    = dx;
  assign creq.dy    = dy;

  hfpd_cordic #(
    .CordicSteps (CORDIC_STEPS)
  ) u_cordic (
    .clk (clk),
    .rst (rst),
    .req (creq),
    .rsp (crsp)
  );

  // Sequencer and stored pose.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      last_x    <= '0;
      last_y    <= '0;
      last_yaw  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_EMIT && emit_ok) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc && !s_axis_tuser) begin
            state <= S_DELTA;
          end
        end
        S_DELTA:  state <= S_SQX;
        S_SQX:    state <= S_SQY;
        S_SQY:    state <= S_SQT;
        S_SQT:    state <= S_DECIDE;
        S_DECIDE: begin
          if (hold_now || is_zero) begin
            state <= S_EMIT;
          end else begin
            state <= S_CWAIT;
          end
        end
        S_CWAIT: begin
          if (crsp.done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            last_x    <= px;
            last_y    <= py;
            last_yaw  <= yaw;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          px <= s_axis_tdata[31:0];
          py <= s_axis_tdata[63:32];
          pz <= s_axis_tdata[95:64];
        end
      end
      S_DELTA: begin
        dx <= DeltaW'(px) - DeltaW'(last_x);
        dy <= DeltaW'(py) - DeltaW'(last_y);
      end
      S_SQX: acc <= prod[SqW-1:0];
      S_SQY: acc <= acc + prod[SqW-1:0];
      S_SQT: tsq <= prod[2*TolW-1:0];
      S_DECIDE: begin
        held <= hold_now;
        if (hold_now) begin
          yaw <= last_yaw;
        end else begin
          yaw <= '0;
        end
      end
      S_CWAIT: begin
        if (crsp.done) begin
          yaw <= crsp.yaw;
        end
      end
      S_EMIT: begin
        if (emit_ok) begin
          out_x    <= px;
          out_y    <= py;
          out_z    <= pz;
          out_yaw  <= yaw;
          out_held <= held;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'b0, out_yaw, out_z, out_y, out_x};
  assign m_axis_tuser  = out_held;

endmodule

/* design/hfpd_checker.sv */
// Port-level checks for the heading block, bound to the top level.
// Depends only on the top level's ports.
module hfpd_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [95:0]  s_axis_tdata,
  input logic         s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [119:0] m_axis_tdata,
  input logic         m_axis_tuser
);

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result item pending after reset");

  // A stalled result item holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result item changed");

  // A fix item occupies the block, so it is not ready in the next cycle.
  a_busy_after_fix: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> !s_axis_tready)
    else $error("ready while a fix item is in work");

  // A no-fix item produces no result.
  a_nofix_silent: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !$rose(m_axis_tvalid))
    else $error("result item after a no-fix item");

  // Result padding bits stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[119:113] == 7'b0))
    else $error("padding bits of result item set");

endmodule

bind heading_from_position_delta_top hfpd_checker u_hfpd_checker (.*);

/* dv/heading_checker.sv */
// Checker for the heading block: watches the item streams and the configuration port.
// It predicts each result and compares it field by field. Depends on hfpd_pkg.
`timescale 1ns / 1ps

module heading_checker #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  input  logic                       s_axis_tready,
  input  logic [95:0]                s_axis_tdata,  // pos_x_mm, pos_y_mm, pos_z_mm
  input  logic                       s_axis_tuser,  // no_fix
  input  logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic [119:0]               m_axis_tdata,  // out_x_mm, out_y_mm, out_z_mm,
                                                    // yaw_deg_q8, zero padding
  input  logic                       m_axis_tuser,  // heading_held
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hfpd_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  input  logic                       pready,
  output int                         mismatches,
  output int                         outstanding
);
  import hfpd_pkg::*;

  localparam longint YawMax = 46080;
  localparam longint BigMove = 65536;

  typedef struct {
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic signed [PosW-1:0] z;
    yaw_t                   yaw;
    logic                   held;
  } heading_result_t;

  heading_result_t heading_q[$];

  // Own copy of the block's state and register.
  longint         prev_x;
  longint         prev_y;
  yaw_t           prev_yaw;
  logic [TolW-1:0] tolerance;
  int             fail_count;

  // Vectoring CORDIC on the movement, giving atan2(dy, dx) in 1/256 degree.
  function automatic yaw_t bearing_q8(longint dx, longint dy);
    longint x;
    longint y;
    longint z;
    longint t;
    longint xs;
    longint ys;
    int     steps;
    x = dx * 1048576;
    y = dy * 1048576;
    z = 0;
    if (dx == 0 && dy == 0) return '0;
    steps = (CORDIC_STEPS > TableLen) ? TableLen : CORDIC_STEPS;
    // Bring the vector into the right half-plane first.
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 90 * 65536;
      end else begin
        t = x; x = -y; y = t; z = -90 * 65536;
      end
    end
    for (int i = 0; i < steps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + longint'(AtanDegQ16[i]);
      end else begin
        x = x - ys; y = y + xs; z = z - longint'(AtanDegQ16[i]);
      end
    end
    z = (z + 128) >>> 8;
    if (z > YawMax) z = YawMax;
    if (z < -YawMax) z = -YawMax;
    return z[YawW-1:0];
  endfunction

  // Works out the result of one fix item and advances the stored pose.
  function automatic heading_result_t predict_heading(logic [95:0] fix);
    heading_result_t r;
    longint dx;
    longint dy;
    longint tol;
    r.x = fix[31:0];
    r.y = fix[63:32];
    r.z = fix[95:64];
    dx = longint'(r.x) - prev_x;
    dy = longint'(r.y) - prev_y;
    tol = longint'(tolerance);
    r.held = 1'b0;
    // Large movement is never below tolerance.
    if (dx > -BigMove && dx < BigMove && dy > -BigMove && dy < BigMove)
      r.held = (dx * dx + dy * dy) < (tol * tol);
    r.yaw = r.held ? prev_yaw : bearing_q8(dx, dy);
    prev_x = longint'(r.x);
    prev_y = longint'(r.y);
    prev_yaw = r.yaw;
    return r;
  endfunction

  function automatic void compare_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  initial fail_count = 0;

  // Results are checked before new items are predicted at each edge.
  always @(posedge clk) begin
    heading_result_t want;
    if (rst) begin
      prev_x = 0;
      prev_y = 0;
      prev_yaw = '0;
      tolerance = TolReset;
      heading_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (heading_q.size() == 0) begin
          $error("result item with no expectation waiting");
          fail_count++;
        end else begin
          want = heading_q.pop_front();
          compare_field("out_x_mm", want.x, $signed(m_axis_tdata[31:0]));
          compare_field("out_y_mm", want.y, $signed(m_axis_tdata[63:32]));
          compare_field("out_z_mm", want.z, $signed(m_axis_tdata[95:64]));
          compare_field("yaw_deg_q8", want.yaw, $signed(m_axis_tdata[112:96]));
          compare_field("heading_held", want.held, m_axis_tuser);
        end
      end
      if (s_axis_tvalid && s_axis_tready && !s_axis_tuser)
        heading_q.push_back(predict_heading(s_axis_tdata));
      // The register index is the word address bit above the byte offset.
      if (psel && penable && pwrite && pready && paddr[2] == RegIdxTolerance)
        tolerance = pwdata[TolW-1:0];
    end
    mismatches <= fail_count;
    outstanding <= heading_q.size();
  end

endmodule

/* dv/tb_heading_from_position_delta_top.sv */
// Testbench top for the heading block: clock, reset, item and register stimulus, verdict.
// Depends on hfpd_pkg, heading_from_position_delta_top and heading_checker.
`timescale 1ns / 1ps

module tb_heading_from_position_delta_top;
  import hfpd_pkg::*;

  localparam int Steps = 16;
  localparam int SettleCycles = Steps + 15;
  localparam int PhaseFixes = 80;
  localparam logic [AddrW-1:0] TolAddr = '0;
  localparam logic [AddrW-1:0] SpareAddr = 3'd4;
  localparam int PosMax = 32'sh7fffffff;
  localparam int PosMin = 32'sh80000000;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [119:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;
  int           mismatches;
  int           outstanding;

  // Idling switches and the walk position used to build plausible tracks.
  logic         send_idle;
  logic         sink_idle;
  int           sink_stall;
  int           walk_x;
  int           walk_y;
  int           cur_tol;

  heading_from_position_delta_top #(.CORDIC_STEPS(Steps)) dut (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  heading_checker #(.CORDIC_STEPS(Steps)) u_heading_checker (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .mismatches, .outstanding
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: stalls come in bursts while idling is enabled.
  always @(posedge clk) begin
    if (sink_stall > 0) begin
      m_axis_tready <= 1'b0;
      sink_stall <= sink_stall - 1;
    end else if (sink_idle && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      sink_stall <= $urandom_range(0, 11);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Sends one item; valid is only lowered when a gap is inserted.
  task automatic send_item(input logic no_fix, input int x, input int y, input int z);
    if (send_idle && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_axis_tdata <= {z, y, x};
    s_axis_tuser <= no_fix;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    if (!no_fix) begin
      walk_x = x;
      walk_y = y;
    end
  endtask

  // Stops the stream and waits until the block has nothing left in flight.
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_register(input logic [AddrW-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_tolerance(input logic [15:0] tol);
    write_register(TolAddr, {16'($urandom()), tol});
    cur_tol = int'(tol);
  endtask

  // Mostly moves along a track with steps of up to 3, 300, 70000 or tolerance + 1, plus noise.
  task automatic random_fix;
    int pick;
    int span;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      send_item(1'b0, $urandom(), $urandom(), $urandom());
    end else begin
      case ($urandom_range(0, 3))
        0: span = 3;
        1: span = 300;
        2: span = 70000;
        default: span = cur_tol + 1;
      endcase
      send_item(1'b0, walk_x + int'($urandom_range(0, 2 * span)) - span,
                walk_y + int'($urandom_range(0, 2 * span)) - span, $urandom());
    end
    // Interleave no-fix items, which must leave the track untouched.
    if ($urandom_range(0, 9) == 0)
      send_item(1'b1, $urandom(), $urandom(), $urandom());
  endtask

  // A fixed upper bound on the run.
  initial begin
    #5000000;
    $display("tb_heading_from_position_delta_top failed");
    $finish;
  end

  initial begin
    logic [15:0] phase_tol [5];
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= 1'b0;
    m_axis_tready <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    sink_stall = 0;
    send_idle = 1'b1;
    sink_idle = 1'b1;
    walk_x = 0;
    walk_y = 0;
    cur_tol = 1;
    rst <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset tolerance: zero movement, each quadrant, extremes.
    send_item(1'b0, 0, 0, 0);
    send_item(1'b1, PosMax, PosMin, -1);
    send_item(1'b0, 1000, 0, -1);
    send_item(1'b0, 1000, 1000, 5);
    send_item(1'b0, 0, 1000, 7);
    send_item(1'b0, 0, 0, 9);
    send_item(1'b0, -1000, -1000, 11);
    send_item(1'b0, -1000, -1000, 13);
    send_item(1'b0, -999, -1000, 15);
    send_item(1'b0, PosMax, PosMax, PosMax);
    send_item(1'b0, PosMin, PosMin, PosMin);
    send_item(1'b0, PosMax, PosMin, 0);
    send_item(1'b0, PosMin, PosMax, PosMax);
    send_item(1'b0, 0, 0, PosMin);
    send_item(1'b1, 0, 0, 0);
    drain();

    // Zero tolerance: standing still is not below it.
    set_tolerance(16'd0);
    send_item(1'b0, 0, 0, 1);
    drain();

    // Widest tolerance, around the large-movement boundary.
    set_tolerance(16'hffff);
    write_register(SpareAddr, 32'd5);
    send_item(1'b0, 65535, 0, 2);
    send_item(1'b0, 131069, 0, 3);
    send_item(1'b0, 131069, -65535, 4);
    send_item(1'b0, 196605, -65535, 5);
    send_item(1'b0, 196605, -65500, 6);
    send_item(1'b0, 196605, -131036, 7);
    drain();

    // Random phases at several tolerances; the last runs without idling.
    phase_tol[0] = 16'($urandom_range(2, 300));
    phase_tol[1] = 16'hffff;
    phase_tol[2] = 16'd0;
    phase_tol[3] = 16'($urandom());
    phase_tol[4] = 16'd20;
    for (int p = 0; p < 5; p++) begin
      set_tolerance(phase_tol[p]);
      if (p == 4) begin
        send_idle = 1'b0;
        sink_idle = 1'b0;
      end
      for (int n = 0; n < PhaseFixes; n++) random_fix();
      drain();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_heading_from_position_delta_top passed");
    end else begin
      $display("tb_heading_from_position_delta_top failed");
    end
    $finish;
  end

endmodule
